FILE: rtl/core/hsb_pkg.sv
// hsb_pkg: shared types and constants for the hsb to rgb888 converter
// used by every stage module and the top level; depends on nothing else

package hsb_pkg;

  // default fraction width of the rounded channel values
  localparam int unsigned FRAC_BITS_DEF = 16;

  // fixed-point one in q.16 and q.32
  localparam logic [16:0] ONE16 = 17'h1_0000;
  localparam logic [32:0] ONE32 = 33'h1_0000_0000;

  // hue sector, floor(6*hue)
  typedef enum logic [2:0] {
    SECT_R_Y = 3'd0,
    SECT_Y_G = 3'd1,
    SECT_G_C = 3'd2,
    SECT_C_B = 3'd3,
    SECT_B_M = 3'd4,
    SECT_M_R = 3'd5
  } sector_t;

  // first stage word: sector, clamped brightness and the three first-level products
  typedef struct packed {
    sector_t     sector;
    logic [16:0] v;
    logic [32:0] sf;   // s*f, q.32
    logic [32:0] sg;   // s*(1-f), q.32
    logic [32:0] pv;   // v*(1-s), q.32
  } hsb_s1_t;

  // second stage word: v, p, q and t as exact q.48 values
  typedef struct packed {
    sector_t     sector;
    logic [48:0] v48;
    logic [48:0] p48;
    logic [48:0] q48;
    logic [48:0] t48;
  } hsb_s2_t;

endpackage

FILE: rtl/core/hsb_if.sv
// hsb_if: valid/ready channel interfaces for the hsb to rgb888 converter
// input word carries hue, saturation, brightness; output word carries red, green, blue

interface hsb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [16:0] saturation;
  logic [16:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/core/hsb_prod.sv
// hsb_prod: first pipeline stage, clamps s and v, splits hue into sector and f,
// and forms s*f, s*(1-f) and v*(1-s); depends on hsb_pkg

module hsb_prod import hsb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] hue,
  input  logic [16:0] saturation,
  input  logic [16:0] brightness,
  output logic        out_valid,
  input  logic        out_ready,
  output hsb_s1_t     out_data
);

  logic    valid_r;
  hsb_s1_t data_r;
  hsb_s1_t data_nxt;

  // stage advances when empty or when the next stage takes its word
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // clamp, sector split and first products
  always_comb begin
    logic [16:0] s_c;
    logic [16:0] v_c;
    logic [18:0] x6;
    logic [16:0] f;
    logic [16:0] fc;
    logic [16:0] sc;
    logic [33:0] sf_full;
    logic [33:0] sg_full;
    logic [33:0] pv_full;
    s_c     = (saturation > ONE16) ? ONE16 : saturation;
    v_c     = (brightness > ONE16) ? ONE16 : brightness;
    x6      = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
    f       = {1'b0, x6[15:0]};
    fc      = ONE16 - f;
    sc      = ONE16 - s_c;
    sf_full = 34'(s_c) * 34'(f);
    sg_full = 34'(s_c) * 34'(fc);
    pv_full = 34'(v_c) * 34'(sc);
    data_nxt.sector = sector_t'(x6[18:16]);
    data_nxt.v      = v_c;
    data_nxt.sf     = sf_full[32:0];
    data_nxt.sg     = sg_full[32:0];
    data_nxt.pv     = pv_full[32:0];
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: rtl/core/hsb_mul.sv
// hsb_mul: second pipeline stage, forms v, p, q and t as exact q.48 values
// depends on hsb_pkg

module hsb_mul import hsb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  hsb_s1_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output hsb_s2_t out_data
);

  logic    valid_r;
  hsb_s2_t data_r;
  hsb_s2_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // q = v*(1-s*f), t = v*(1-s*(1-f)), both at most 1.0 in q.48
  always_comb begin
    logic [32:0] dq;
    logic [32:0] dt;
    logic [49:0] q_full;
    logic [49:0] t_full;
    dq     = ONE32 - in_data.sf;
    dt     = ONE32 - in_data.sg;
    q_full = 50'(in_data.v) * 50'(dq);
    t_full = 50'(in_data.v) * 50'(dt);
    data_nxt.sector = in_data.sector;
    data_nxt.v48    = {in_data.v, 32'h0};
    data_nxt.p48    = {in_data.pv, 16'h0};
    data_nxt.q48    = q_full[48:0];
    data_nxt.t48    = t_full[48:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: rtl/core/hsb_route.sv
// hsb_route: third pipeline stage, rounds v, p, q, t to q.FRAC_BITS and
// steers them to red, green and blue by sector; depends on hsb_pkg

module hsb_route import hsb_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsb_s2_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   out_r,
  output logic [FRAC_BITS:0]   out_g,
  output logic [FRAC_BITS:0]   out_b
);

  localparam int unsigned SH = 48 - FRAC_BITS;
  localparam logic [49:0] HALF = 50'(1) << (SH - 1);

  logic               valid_r;
  logic [FRAC_BITS:0] r_r, g_r, b_r;
  logic [FRAC_BITS:0] r_nxt, g_nxt, b_nxt;
  logic [49:0]        v_sum, p_sum, q_sum, t_sum;
  logic [FRAC_BITS:0] vq, pq, qq, tq;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_r     = r_r;
  assign out_g     = g_r;
  assign out_b     = b_r;

  // round half up from q.48
  assign v_sum = {1'b0, in_data.v48} + HALF;
  assign p_sum = {1'b0, in_data.p48} + HALF;
  assign q_sum = {1'b0, in_data.q48} + HALF;
  assign t_sum = {1'b0, in_data.t48} + HALF;
  assign vq    = v_sum[SH+FRAC_BITS:SH];
  assign pq    = p_sum[SH+FRAC_BITS:SH];
  assign qq    = q_sum[SH+FRAC_BITS:SH];
  assign tq    = t_sum[SH+FRAC_BITS:SH];

  // sector routing
  always_comb begin
    case (in_data.sector)
      SECT_R_Y: begin r_nxt = vq; g_nxt = tq; b_nxt = pq; end
      SECT_Y_G: begin r_nxt = qq; g_nxt = vq; b_nxt = pq; end
      SECT_G_C: begin r_nxt = pq; g_nxt = vq; b_nxt = tq; end
      SECT_C_B: begin r_nxt = pq; g_nxt = qq; b_nxt = vq; end
      SECT_B_M: begin r_nxt = tq; g_nxt = pq; b_nxt = vq; end
      default:  begin r_nxt = vq; g_nxt = pq; b_nxt = qq; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      r_r <= r_nxt;
      g_r <= g_nxt;
      b_r <= b_nxt;
    end
  end

endmodule

FILE: rtl/core/hsb_pack.sv
// hsb_pack: last pipeline stage and output register, turns each channel
// into round(255*x) saturated to a byte; depends on hsb_pkg

module hsb_pack import hsb_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FRAC_BITS:0] in_r,
  input  logic [FRAC_BITS:0] in_g,
  input  logic [FRAC_BITS:0] in_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  localparam int unsigned PW = FRAC_BITS + 9;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic       valid_r;
  logic [7:0] red_r, green_r, blue_r;
  logic [7:0] red_nxt, green_nxt, blue_nxt;

  // 255*x + half, shifted down and limited to 255
  function automatic logic [7:0] to_byte(input logic [PW-1:0] x);
    logic [PW-1:0] acc;
    logic [8:0]    b;
    acc = (x << 8) - x + HALF;
    b   = acc[FRAC_BITS+8:FRAC_BITS];
    return b[8] ? 8'hff : b[7:0];
  endfunction

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

  // byte conversion
  assign red_nxt   = to_byte(PW'(in_r));
  assign green_nxt = to_byte(PW'(in_g));
  assign blue_nxt  = to_byte(PW'(in_b));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

endmodule

FILE: rtl/core/hsb_to_rgb888.sv
// hsb_to_rgb888: hsb pixel to 8-bit rgb, four register stages
// an accepted input word passes the prod, mul, route and pack registers in order to the output
// throughput: one word per cycle unless the output stalls, each stage holds a word and advances when the next frees
// output stalls back-pressure the chain through per-stage ready, nothing lost or repeated
// reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset
// depends on hsb_pkg, hsb_if and the stage modules hsb_prod, hsb_mul, hsb_route, hsb_pack

module hsb_to_rgb888 import hsb_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hsb_in_if.sink    in_ch,
  hsb_out_if.source out_ch
);

  logic               s1_valid, s1_ready;
  hsb_s1_t            s1_data;
  logic               s2_valid, s2_ready;
  hsb_s2_t            s2_data;
  logic               s3_valid, s3_ready;
  logic [FRAC_BITS:0] s3_r, s3_g, s3_b;

  // clamp, sector split, first products
  hsb_prod u_prod (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .hue        (in_ch.hue),
    .saturation (in_ch.saturation),
    .brightness (in_ch.brightness),
    .out_valid  (s1_valid),
    .out_ready  (s1_ready),
    .out_data   (s1_data)
  );

  // q.48 values
  hsb_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // rounding and sector routing
  hsb_route #(.FRAC_BITS(FRAC_BITS)) u_route (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_r     (s3_r),
    .out_g     (s3_g),
    .out_b     (s3_b)
  );

  // byte conversion and output register
  hsb_pack #(.FRAC_BITS(FRAC_BITS)) u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_r      (s3_r),
    .in_g      (s3_g),
    .in_b      (s3_b),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .red       (out_ch.red),
    .green     (out_ch.green),
    .blue      (out_ch.blue)
  );

endmodule

FILE: rtl/core/hsb_chk.sv
// hsb_chk: port-level checks for hsb_to_rgb888, bound to the top level
// watches the handshakes and the bytes of a stalled output word; depends on nothing else

module hsb_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  localparam logic [2:0] DEPTH = 3'd4;

  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words in flight
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 3'd1;
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // a stalled output word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // a stalled output word keeps its bytes
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
    else $error("output word changed while stalled");

  // no output word without an accepted input word behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("output word with nothing in flight");

  // the pipeline never holds more than its stages
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH)
    else $error("more words in flight than stages");

  // input stalls only when the full pipeline is blocked at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && cnt_r == DEPTH)
    else $error("input stalled without output back-pressure");

endmodule

bind hsb_to_rgb888 hsb_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red       (out_ch.red),
  .green     (out_ch.green),
  .blue      (out_ch.blue)
);

FILE: verif/testbench.sv
// testbench: self-checking bench for the hsb_to_rgb888 pixel converter
// predicts red, green and blue per accepted word and checks the output stream in order
// depends on hsb_pkg and the hsb_in_if / hsb_out_if channel interfaces

module testbench import hsb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_CFG = FRAC_BITS_DEF;

  // expected output word
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_word_t;

  logic clk;
  logic rst_n;

  hsb_in_if  in_ch ();
  hsb_out_if out_ch ();

  hsb_to_rgb888 #(.FRAC_BITS(FRAC_CFG)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rgb_word_t pending_rgb[$];
  int        error_count   = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // timeout
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  // round an exact q.48 value half up to q.FRAC_CFG
  function automatic logic [63:0] round_frac(logic [63:0] x48);
    int unsigned sh;
    sh = 48 - FRAC_CFG;
    return (x48 + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // round(255*x) with saturation to one byte
  function automatic logic [7:0] scale_to_byte(logic [63:0] xf);
    logic [63:0] b;
    b = (64'd255 * xf + (64'd1 << (FRAC_CFG - 1))) >> FRAC_CFG;
    return (b > 64'd255) ? 8'd255 : b[7:0];
  endfunction

  // full hsb to rgb888 conversion of one pixel
  function automatic rgb_word_t convert_pixel(logic [15:0] hue, logic [16:0] sat,
                                              logic [16:0] bri);
    logic [63:0] one16, one32, s, v, x6, f, vq, pq, qq, tq, r, g, b;
    sector_t     sect;
    rgb_word_t   px;
    one16 = 64'(ONE16);
    one32 = 64'(ONE32);
    // saturation and brightness above one are clamped
    s = (64'(sat) > one16) ? one16 : 64'(sat);
    v = (64'(bri) > one16) ? one16 : 64'(bri);
    x6 = 64'd6 * 64'(hue);
    sect = sector_t'(x6[18:16]);
    f = x6 & 64'hFFFF;
    vq = round_frac(v << 32);
    pq = round_frac((v * (one16 - s)) << 16);
    qq = round_frac(v * (one32 - s * f));
    tq = round_frac(v * (one32 - s * (one16 - f)));
    case (sect)
      SECT_R_Y: begin r = vq; g = tq; b = pq; end
      SECT_Y_G: begin r = qq; g = vq; b = pq; end
      SECT_G_C: begin r = pq; g = vq; b = tq; end
      SECT_C_B: begin r = pq; g = qq; b = vq; end
      SECT_B_M: begin r = tq; g = pq; b = vq; end
      default: begin r = vq; g = pq; b = qq; end
    endcase
    px.red   = scale_to_byte(r);
    px.green = scale_to_byte(g);
    px.blue  = scale_to_byte(b);
    return px;
  endfunction

  // receiver: random stalls plus a counted hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_left = hold_off_left - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // output checker against the oldest expected word
  always @(posedge clk) begin
    rgb_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected word red %0d green %0d blue %0d", $time,
                 out_ch.red, out_ch.green, out_ch.blue);
        error_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (out_ch.red !== want.red) begin
          $display("%0t: red mismatch expected %0d actual %0d", $time, want.red, out_ch.red);
          error_count++;
        end
        if (out_ch.green !== want.green) begin
          $display("%0t: green mismatch expected %0d actual %0d", $time, want.green,
                   out_ch.green);
          error_count++;
        end
        if (out_ch.blue !== want.blue) begin
          $display("%0t: blue mismatch expected %0d actual %0d", $time, want.blue,
                   out_ch.blue);
          error_count++;
        end
      end
    end
  end

  // send one word, with random idle cycles ahead of it
  task automatic send_pixel(logic [15:0] hue, logic [16:0] sat, logic [16:0] bri);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.hue        <= hue;
    in_ch.saturation <= sat;
    in_ch.brightness <= bri;
    do @(posedge clk); while (!in_ch.ready);
    pending_rgb.push_back(convert_pixel(hue, sat, bri));
  endtask

  // stop offering words and wait for every expected word
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  // saturation or brightness level, weighted toward the edges
  function automatic logic [16:0] pick_level();
    case ($urandom_range(9))
      0:       return 17'd0;
      1:       return 17'h10000;
      2:       return 17'($urandom_range(131071, 65537));
      3:       return 17'($urandom_range(255));
      4:       return 17'($urandom_range(65536, 65280));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // hue, mostly uniform, sometimes right at a sector boundary
  function automatic logic [15:0] pick_hue();
    int k;
    if ($urandom_range(4) == 0) begin
      k = $urandom_range(5, 1);
      return 16'((k * 65536 + 5) / 6 + $urandom_range(2) - 1);
    end
    return 16'($urandom_range(65535));
  endfunction

  task automatic send_random_pixels(int count);
    for (int i = 0; i < count; i++) send_pixel(pick_hue(), pick_level(), pick_level());
  endtask

  // black, white, grey, clamped levels and all-ones fields
  task automatic test_level_extremes();
    send_pixel(16'd0, 17'd0, 17'd0);
    send_pixel(16'd0, 17'd0, 17'h10000);
    send_pixel(16'd12345, 17'd0, 17'd40000);
    send_pixel(16'd0, 17'h10000, 17'h10000);
    send_pixel(16'hFFFF, 17'h10000, 17'h10000);
    send_pixel(16'd0, 17'h1FFFF, 17'h1FFFF);
    send_pixel(16'd21845, 17'h10001, 17'd99999);
    send_pixel(16'd40000, 17'h10000, 17'd0);
    send_pixel(16'h5555, 17'h0AAAA, 17'h15555);
    wait_drained();
  endtask

  // both sides of each sector boundary, then the middle of each sector
  task automatic test_sector_edges();
    for (int k = 1; k < 6; k++) begin
      send_pixel(16'((k * 65536 + 5) / 6 - 1), 17'h10000, 17'h10000);
      send_pixel(16'((k * 65536 + 5) / 6), 17'h10000, 17'h10000);
    end
    for (int k = 0; k < 6; k++) send_pixel(16'((k * 65536 + 32768) / 6), 17'd50000, 17'd60000);
    wait_drained();
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_pixels(320);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 80;
    recv_stall_pct = 0;
    send_random_pixels(320);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 80;
    send_random_pixels(320);
  endtask

  task automatic test_mixed_gaps();
    send_idle_pct = 30;
    recv_stall_pct = 30;
    send_random_pixels(320);
  endtask

  // long output hold-off while words keep coming, so the pipeline fills and stalls input
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_left = 300;
    send_random_pixels(40);
    wait_drained();
  endtask

  // sender pauses until the pipeline is empty, then resumes
  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_stall_pct = 20;
    send_random_pixels(20);
    wait_drained();
    send_random_pixels(20);
  endtask

  // test sequence
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.hue = '0;
    in_ch.saturation = '0;
    in_ch.brightness = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_level_extremes();
    test_sector_edges();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    test_output_hold_off();
    test_drain_pause();

    recv_stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: hsb_to_rgb888.f
rtl/core/hsb_pkg.sv
rtl/core/hsb_if.sv
rtl/core/hsb_prod.sv
rtl/core/hsb_mul.sv
rtl/core/hsb_route.sv
rtl/core/hsb_pack.sv
rtl/core/hsb_to_rgb888.sv
rtl/core/hsb_chk.sv
verif/testbench.sv
